### src/sli_pkg.sv
// Shared constants and types for the sorted list intersection core.
// No dependencies; imported by sorted_list_intersection_core.
`default_nettype none

package sli_pkg;

  // List store geometry
  localparam int LIST_DEPTH = 64;
  localparam int LIST_AW    = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  // Payload widths
  localparam int ID_W     = 16;
  localparam int ACTION_W = 2;

  // Input transaction kinds (carried on s_axis_tuser)
  typedef enum logic [ACTION_W-1:0] {
    ACT_LOAD_FIRST  = 2'd0,
    ACT_LOAD_SECOND = 2'd1,
    ACT_RUN         = 2'd2
  } action_t;

  // Control states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

endpackage

`default_nettype wire

### src/sorted_list_intersection_core.sv
// Sorted list intersection core: two list memories and a merge-walk sequencer.
// Depends on sli_pkg.
//
// Input stream (s_axis_*): tuser carries the action, tdata the document id.
// "Load first" / "load second" appends the id to that list; ids are expected
// strictly ascending. "Run" walks both lists and streams every common id in
// ascending order on m_axis_*, tlast on the final one. With no common id (or an
// empty list) one transaction with match_valid clear is sent. tuser[1] reports
// loads dropped on a full list since the previous run. A run empties both lists
// and clears that flag.
// Timing: loads stream back to back. A run has an accept step, compare steps
// (none if a list is empty) and a closing step; one compare per cycle while the
// walk is not frozen by a stall, set by the single registered read port of each
// list memory. The input is not ready during a run and reopens the cycle after
// closing, even while the final result waits. A match is held until the next
// match or the close so tlast can be attached.
// Stall: with m_axis_tready low and a result pending, the walk freezes before it
// would produce another result; nothing is lost.
// Reset (rst, synchronous): both lists empty, flag clear, output empty. The
// memories are not cleared; only counted entries are read.
`default_nettype none

module sorted_list_intersection_core
  import sli_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  // input stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [ID_W-1:0]     s_axis_tdata,   // [15:0] doc_id
  input  wire logic [ACTION_W-1:0] s_axis_tuser,   // [1:0] action
  // result stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [ID_W-1:0]          m_axis_tdata,   // [15:0] match_id
  output logic [1:0]               m_axis_tuser,   // [0] match_valid, [1] overflowed
  output logic                     m_axis_tlast    // last
);

  // List memories
  logic [ID_W-1:0] first_mem  [LIST_DEPTH];
  logic [ID_W-1:0] second_mem [LIST_DEPTH];
  logic [ID_W-1:0] rd_first;
  logic [ID_W-1:0] rd_second;
  logic [LIST_AW-1:0] addr_first;
  logic [LIST_AW-1:0] addr_second;

  // Control state
  state_t          state, state_next;
  logic [CNT_W-1:0] first_count, second_count;
  logic            overflow_flag;
  logic [CNT_W-1:0] a_idx, b_idx;
  logic [CNT_W-1:0] a_next, b_next;
  logic            hold_valid;
  logic [ID_W-1:0] hold_id;

  // Output register
  logic            out_valid;
  logic [ID_W-1:0] out_id;
  logic            out_mv;
  logic            out_last;
  logic            out_ovf;

  // Combinational controls
  action_t         act;
  logic            in_fire;
  logic            walk_more;
  logic            ids_equal;
  logic            first_lower;
  logic            out_free;
  logic            a_step, b_step;
  logic            push;
  logic [ID_W-1:0] push_id;
  logic            push_mv;
  logic            push_last;
  logic            hold_load;
  logic            run_done;

  assign act         = action_t'(s_axis_tuser);
  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign walk_more   = (a_idx < first_count) && (b_idx < second_count);
  assign ids_equal   = (rd_first == rd_second);
  assign first_lower = (rd_first < rd_second);
  assign out_free    = !out_valid || m_axis_tready;
  assign a_next      = a_idx + CNT_W'(a_step);
  assign b_next      = b_idx + CNT_W'(b_step);

  // Next-state and walk decisions
  always_comb begin
    state_next = state;
    a_step     = 1'b0;
    b_step     = 1'b0;
    push       = 1'b0;
    push_id    = '0;
    push_mv    = 1'b0;
    push_last  = 1'b0;
    hold_load  = 1'b0;
    run_done   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_fire && act == ACT_RUN) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (walk_more) begin
          if (ids_equal) begin
            // a new match pushes the previously held one out
            if (!hold_valid || out_free) begin
              a_step    = 1'b1;
              b_step    = 1'b1;
              hold_load = 1'b1;
              push      = hold_valid;
              push_id   = hold_id;
              push_mv   = 1'b1;
            end
          end else if (first_lower) begin
            a_step = 1'b1;
          end else begin
            b_step = 1'b1;
          end
        end else if (out_free) begin
          // closing transaction: held match or empty answer, marked last
          push       = 1'b1;
          push_id    = hold_valid ? hold_id : '0;
          push_mv    = hold_valid;
          push_last  = 1'b1;
          run_done   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Read addresses follow the step decision so data is ready next cycle
  always_comb begin
    if (state == ST_RUN) begin
      addr_first  = a_next[LIST_AW-1:0];
      addr_second = b_next[LIST_AW-1:0];
    end else begin
      addr_first  = '0;
      addr_second = '0;
    end
  end

  // Memory writes on loads, registered reads
  always_ff @(posedge clk) begin
    if (in_fire && act == ACT_LOAD_FIRST && first_count < CNT_W'(LIST_DEPTH)) begin
      first_mem[first_count[LIST_AW-1:0]] <= s_axis_tdata;
    end
    if (in_fire && act == ACT_LOAD_SECOND && second_count < CNT_W'(LIST_DEPTH)) begin
      second_mem[second_count[LIST_AW-1:0]] <= s_axis_tdata;
    end
    rd_first  <= first_mem[addr_first];
    rd_second <= second_mem[addr_second];
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Counts, overflow flag, walk indices and held match
  always_ff @(posedge clk) begin
    if (rst) begin
      first_count   <= '0;
      second_count  <= '0;
      overflow_flag <= 1'b0;
      a_idx         <= '0;
      b_idx         <= '0;
      hold_valid    <= 1'b0;
    end else begin
      if (in_fire) begin
        case (act)
          ACT_LOAD_FIRST: begin
            if (first_count < CNT_W'(LIST_DEPTH)) begin
              first_count <= first_count + CNT_W'(1);
            end else begin
              overflow_flag <= 1'b1;
            end
          end
          ACT_LOAD_SECOND: begin
            if (second_count < CNT_W'(LIST_DEPTH)) begin
              second_count <= second_count + CNT_W'(1);
            end else begin
              overflow_flag <= 1'b1;
            end
          end
          ACT_RUN: begin
            a_idx      <= '0;
            b_idx      <= '0;
            hold_valid <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (state == ST_RUN) begin
        a_idx <= a_next;
        b_idx <= b_next;
      end
      if (hold_load) begin
        hold_valid <= 1'b1;
      end
      if (run_done) begin
        first_count   <= '0;
        second_count  <= '0;
        overflow_flag <= 1'b0;
        hold_valid    <= 1'b0;
      end
    end
  end

  // Held match payload
  always_ff @(posedge clk) begin
    if (hold_load) begin
      hold_id <= rd_first;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_id   <= push_id;
      out_mv   <= push_mv;
      out_last <= push_last;
      out_ovf  <= overflow_flag;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_id;
  assign m_axis_tuser  = {out_ovf, out_mv};
  assign m_axis_tlast  = out_last;

  // Checks
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (a_idx <= first_count && b_idx <= second_count))
    else $error("walk index passed list count");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast)
    else $error("empty answer without last mark");

  a_run_clears: assert property (@(posedge clk) disable iff (rst)
    run_done |=> (first_count == '0 && second_count == '0 && !overflow_flag
                  && state == ST_IDLE && m_axis_tvalid && m_axis_tlast))
    else $error("run did not close cleanly");

  a_hold_in_run: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> (state == ST_RUN))
    else $error("held match outside a run");

endmodule

`default_nettype wire
